// ----- sv/fhm_pkg.sv -----
// Shared constants, types and the arctangent table for the flow harmonic
// modulation block. No dependencies.
`default_nettype none

package fhm_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int NUM_HARMONICS = 3;
    localparam int NUM_LANES     = 3;
    localparam int CORDIC_STEPS  = 16;
    localparam int PHASE_W       = 32;
    localparam int XY_W          = 33;
    localparam int CS_W          = 26;
    localparam int CFG_W         = 32;
    localparam int PROD_W        = CFG_W + CS_W;
    localparam int PAIR_W        = PROD_W + 1;
    localparam int SUM_W         = PAIR_W + 3;
    localparam int MAG_W         = SUM_W - 1;
    localparam int NUM_W         = SUM_W;
    localparam int DEN_W         = CFG_W + 8;
    localparam int QUO_BITS      = 21;
    localparam int RES_W         = QUO_BITS + 2;
    localparam int OUT_W         = 20;
    localparam int ENA_W         = 3;
    localparam int IDX_W         = 3;
    localparam int ROUND_SHIFT   = 6;

    localparam logic signed [XY_W-1:0]  INV_GAIN = 33'sd652032874;
    localparam logic signed [XY_W-1:0]  ROUND_ADD = 33'sd32;
    localparam logic signed [OUT_W-1:0] OUT_MAX  = 20'sd524287;
    localparam logic signed [OUT_W-1:0] OUT_MIN  = -20'sd524288;
    localparam logic signed [OUT_W-1:0] ONE_Q16  = 20'sd65536;

    typedef enum logic [IDX_W-1:0] {
        REG_TOTAL_ET,
        REG_Q2_COS,
        REG_Q2_SIN,
        REG_Q3_COS,
        REG_Q3_SIN,
        REG_Q4_COS,
        REG_Q4_SIN,
        REG_ENABLE
    } cfg_reg_t;

    typedef struct packed {
        logic active;
        logic neg;
    } fhm_meta_t;

    function automatic logic signed [XY_W-1:0] atan_turn(input int unsigned step);
        logic signed [XY_W-1:0] v;
        case (step)
            0:       v = 33'sd536870912;
            1:       v = 33'sd316933406;
            2:       v = 33'sd167458907;
            3:       v = 33'sd85004756;
            4:       v = 33'sd42667331;
            5:       v = 33'sd21354465;
            6:       v = 33'sd10679838;
            7:       v = 33'sd5340245;
            8:       v = 33'sd2670163;
            9:       v = 33'sd1335087;
            10:      v = 33'sd667544;
            11:      v = 33'sd333772;
            12:      v = 33'sd166886;
            13:      v = 33'sd83443;
            14:      v = 33'sd41722;
            15:      v = 33'sd20861;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/fhm_cordic.sv -----
// One sin/cos lane: range reduction, pipelined rotation steps, Q24 rounding.
// Depends on fhm_pkg.
`default_nettype none

module fhm_cordic (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv,
    input  wire logic                                in_vld,
    input  wire logic [fhm_pkg::PHASE_W-1:0]         phase,
    output logic                                     out_vld,
    output logic signed [fhm_pkg::CS_W-1:0]          cos_q,
    output logic signed [fhm_pkg::CS_W-1:0]          sin_q
);
    import fhm_pkg::*;

    logic [CORDIC_STEPS+1:0]  vld_reg;
    logic signed [XY_W-1:0]   x_reg [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]   y_reg [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]   z_reg [0:CORDIC_STEPS];
    logic                     flip_reg [0:CORDIC_STEPS];
    logic                     flip_next;
    logic [PHASE_W-1:0]       red_phase;
    logic signed [XY_W-1:0]   xr, yr;
    logic signed [CS_W-1:0]   cos_reg, sin_reg, cos_next, sin_next;

    always_comb
    begin
        flip_next = (phase[PHASE_W-1:PHASE_W-2] == 2'b01) ||
                    (phase[PHASE_W-1:PHASE_W-2] == 2'b10);
        red_phase = {phase[PHASE_W-1] ^ flip_next, phase[PHASE_W-2:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[CORDIC_STEPS:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]    <= INV_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= {red_phase[PHASE_W-1], red_phase};
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [XY_W-1:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!z_reg[i][XY_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_turn(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_turn(i);
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    always_comb
    begin
        xr = (x_reg[CORDIC_STEPS] + ROUND_ADD) >>> ROUND_SHIFT;
        yr = (y_reg[CORDIC_STEPS] + ROUND_ADD) >>> ROUND_SHIFT;
        cos_next = flip_reg[CORDIC_STEPS] ? -xr[CS_W-1:0] : xr[CS_W-1:0];
        sin_next = flip_reg[CORDIC_STEPS] ? -yr[CS_W-1:0] : yr[CS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign out_vld = vld_reg[CORDIC_STEPS+1];
    assign cos_q   = cos_reg;
    assign sin_q   = sin_reg;

endmodule

`default_nettype wire

// ----- sv/fhm_div.sv -----
// Pipelined restoring divider with round-to-nearest, offset by one and clip.
// Depends on fhm_pkg.
`default_nettype none

module fhm_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              adv,
    input  wire logic                              in_vld,
    input  wire logic [fhm_pkg::MAG_W-1:0]         mag,
    input  wire logic [fhm_pkg::CFG_W-1:0]         et,
    input  wire fhm_pkg::fhm_meta_t                meta,
    output logic                                   out_vld,
    output logic signed [fhm_pkg::OUT_W-1:0]       modulation,
    output logic                                   saturated
);
    import fhm_pkg::*;

    logic [QUO_BITS+1:0]      vld_reg;
    logic [NUM_W-1:0]         rem_reg  [0:QUO_BITS];
    logic [DEN_W-1:0]         den_reg  [0:QUO_BITS];
    logic [QUO_BITS-1:0]      quo_reg  [0:QUO_BITS];
    fhm_meta_t                meta_reg [0:QUO_BITS];
    logic                     big_reg  [1:QUO_BITS];
    logic signed [OUT_W-1:0]  mod_reg, mod_next;
    logic                     sat_reg, sat_next;
    logic signed [RES_W-1:0]  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[QUO_BITS:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= NUM_W'(mag) + (NUM_W'(et) << 7);
            den_reg[0]  <= DEN_W'(et) << 8;
            quo_reg[0]  <= '0;
            meta_reg[0] <= meta;
        end
    end

    for (genvar j = 0; j < QUO_BITS; j++)
    begin : g_bit
        logic [NUM_W-1:0] trial;
        logic             ge;
        assign trial = NUM_W'(den_reg[j]) << (QUO_BITS - 1 - j);
        assign ge    = rem_reg[j] >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j+1]  <= ge ? rem_reg[j] - trial : rem_reg[j];
                den_reg[j+1]  <= den_reg[j];
                quo_reg[j+1]  <= {quo_reg[j][QUO_BITS-2:0], ge};
                meta_reg[j+1] <= meta_reg[j];
            end
        end

        if (j == 0)
        begin : g_big
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    big_reg[1] <= rem_reg[0] >= (NUM_W'(den_reg[0]) << QUO_BITS);
                end
            end
        end
        else
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    big_reg[j+1] <= big_reg[j];
                end
            end
        end
    end

    always_comb
    begin
        res = meta_reg[QUO_BITS].neg
            ? RES_W'(ONE_Q16) - $signed({2'b00, quo_reg[QUO_BITS]})
            : RES_W'(ONE_Q16) + $signed({2'b00, quo_reg[QUO_BITS]});
        mod_next = res[OUT_W-1:0];
        sat_next = 1'b0;
        if (!meta_reg[QUO_BITS].active)
        begin
            mod_next = ONE_Q16;
        end
        else if (big_reg[QUO_BITS])
        begin
            mod_next = meta_reg[QUO_BITS].neg ? OUT_MIN : OUT_MAX;
            sat_next = 1'b1;
        end
        else if (res > RES_W'(OUT_MAX))
        begin
            mod_next = OUT_MAX;
            sat_next = 1'b1;
        end
        else if (res < RES_W'(OUT_MIN))
        begin
            mod_next = OUT_MIN;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mod_reg <= mod_next;
            sat_reg <= sat_next;
        end
    end

    assign out_vld    = vld_reg[QUO_BITS+1];
    assign modulation = mod_reg;
    assign saturated  = sat_reg;

endmodule

`default_nettype wire

// ----- sv/flow_harmonic_modulation.sv -----
// Usage: one request on the input channel carries an azimuth angle (2^16 =
// one full turn); one request on the output channel returns the modulation
// factor in signed Q3.16 and a flag set when it was clipped to range.
// Configuration: event sums, total energy and the harmonic enable mask are
// written through cfg_write/cfg_index/cfg_data; write only while no request
// is in flight. A non-positive total energy gives exactly 1.0.
// Pipeline: a request passes 18 sin/cos stages, 4 multiply and sum stages
// and 23 divider stages before it shows on out_valid.
// Throughput: one request per cycle while the pipeline is not stalled;
// every stage is a register that moves with the whole pipeline.
// Stall: while out_valid and out_stall are both high the whole pipeline
// holds and in_stall is high; nothing is dropped or repeated.
// Reset: rst_n clears all valid bits and the configuration registers.
// Depends on fhm_pkg, fhm_cordic, fhm_div.
`default_nettype none

module flow_harmonic_modulation (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [fhm_pkg::ANGLE_BITS-1:0]      angle,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [fhm_pkg::OUT_W-1:0]         modulation,
    output logic                                     saturated,
    input  wire logic                                cfg_write,
    input  wire logic [fhm_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [fhm_pkg::CFG_W-1:0]           cfg_data
);
    import fhm_pkg::*;

    logic                      adv;
    logic signed [CFG_W-1:0]   total_et_reg;
    logic signed [CFG_W-1:0]   q_cos_reg [0:NUM_LANES-1];
    logic signed [CFG_W-1:0]   q_sin_reg [0:NUM_LANES-1];
    logic [ENA_W-1:0]          enable_reg;
    logic [PHASE_W-1:0]        phi;
    logic [NUM_LANES-1:0]      lane_vld;
    logic                      lanes_vld;
    logic signed [CS_W-1:0]    lane_cos [0:NUM_LANES-1];
    logic signed [CS_W-1:0]    lane_sin [0:NUM_LANES-1];
    logic                      vld_m_reg, vld_a_reg, vld_b_reg, vld_c_reg;
    logic signed [PROD_W-1:0]  pc_reg [0:NUM_LANES-1];
    logic signed [PROD_W-1:0]  ps_reg [0:NUM_LANES-1];
    logic signed [PAIR_W-1:0]  pair_reg [0:NUM_LANES-1];
    logic signed [SUM_W-1:0]   sum2_reg;
    logic signed [SUM_W-1:0]   mag_full;
    logic [MAG_W-1:0]          mag_reg;
    fhm_meta_t                 meta_c_reg, meta_c_next;

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_et_reg <= '0;
            enable_reg   <= '0;
            for (int k = 0; k < NUM_LANES; k++)
            begin
                q_cos_reg[k] <= '0;
                q_sin_reg[k] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TOTAL_ET: total_et_reg <= cfg_data;
                REG_Q2_COS:   q_cos_reg[0] <= cfg_data;
                REG_Q2_SIN:   q_sin_reg[0] <= cfg_data;
                REG_Q3_COS:   q_cos_reg[1] <= cfg_data;
                REG_Q3_SIN:   q_sin_reg[1] <= cfg_data;
                REG_Q4_COS:   q_cos_reg[2] <= cfg_data;
                REG_Q4_SIN:   q_sin_reg[2] <= cfg_data;
                REG_ENABLE:   enable_reg   <= cfg_data[ENA_W-1:0];
                default:      ;
            endcase
        end
    end

    assign phi = PHASE_W'(angle) << (PHASE_W - ANGLE_BITS);

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        logic [PHASE_W-1:0]       lane_phase;
        logic                     lane_on;
        logic signed [PROD_W-1:0] prod_c, prod_s;
        assign lane_phase = PHASE_W'(phi * PHASE_W'(k + 2));
        assign lane_on    = enable_reg[k] && (k < NUM_HARMONICS);
        assign prod_c     = lane_cos[k] * q_cos_reg[k];
        assign prod_s     = lane_sin[k] * q_sin_reg[k];

        fhm_cordic u_cordic (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .in_vld  (in_valid),
            .phase   (lane_phase),
            .out_vld (lane_vld[k]),
            .cos_q   (lane_cos[k]),
            .sin_q   (lane_sin[k])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pc_reg[k]   <= lane_on ? prod_c : '0;
                ps_reg[k]   <= lane_on ? prod_s : '0;
                pair_reg[k] <= PAIR_W'(pc_reg[k]) + PAIR_W'(ps_reg[k]);
            end
        end
    end

    assign lanes_vld = &lane_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_m_reg <= 1'b0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_m_reg <= lanes_vld;
            vld_a_reg <= vld_m_reg;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    always_comb
    begin
        meta_c_next.neg    = sum2_reg[SUM_W-1];
        meta_c_next.active = total_et_reg > 0;
        mag_full           = meta_c_next.neg ? -sum2_reg : sum2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum2_reg   <= (SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]) +
                           SUM_W'(pair_reg[2])) <<< 1;
            mag_reg    <= mag_full[MAG_W-1:0];
            meta_c_reg <= meta_c_next;
        end
    end

    fhm_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_vld     (vld_c_reg),
        .mag        (mag_reg),
        .et         (total_et_reg),
        .meta       (meta_c_reg),
        .out_vld    (out_valid),
        .modulation (modulation),
        .saturated  (saturated)
    );

`ifndef NO_ASSERTIONS
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> modulation == OUT_MAX || modulation == OUT_MIN)
        else $error("saturated result not at a bound");

    a_mult_follow: assert property (@(posedge clk) disable iff (!rst_n)
        lanes_vld && !in_stall |=> vld_m_reg)
        else $error("lane result lost at multiply stage");

    a_neg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_c_reg |-> !(meta_c_reg.neg && mag_reg == '0))
        else $error("negative sum with zero magnitude");
`endif

endmodule

`default_nettype wire
